FILE: sv/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg
// shared widths and pipeline types for the waveform pair similarity scorer
// ----------------------------------------------------------------------------
`default_nettype none

package wps_pkg;

    localparam int RAW_W   = 16;
    localparam int CLIP_W  = 13;
    localparam int FIELDS  = 6;
    localparam int PROD_W  = 2 * CLIP_W;
    localparam int SUM_W   = PROD_W + 3;
    localparam int NORM_W  = 2 * SUM_W;
    localparam int DEN_W   = NORM_W + 30;
    localparam int ACC_W   = NORM_W + 34;
    localparam int Q_W     = 16;
    localparam int LANES   = 3;
    localparam int STEPS   = 16;
    localparam logic [Q_W-1:0] ONE_Q15 = 16'h8000;

    typedef struct packed {
        logic              nz;
        logic [NORM_W-1:0] p;
        logic [DEN_W-1:0]  d;
        logic [ACC_W-1:0]  s;
        logic [ACC_W-1:0]  a;
        logic [Q_W-1:0]    r;
    } lane_t;

    typedef struct packed {
        logic [SUM_W-1:0] dot;
        logic [SUM_W-1:0] nu;
        logic [SUM_W-1:0] nv;
    } sums_t;

endpackage

`default_nettype wire

FILE: sv/waveform_pair_similarity.sv
// ----------------------------------------------------------------------------
// waveform_pair_similarity
// cosine similarity and best shifted normalized correlation of a u/v pair
// ----------------------------------------------------------------------------
// One pair of waveforms enters per cycle unless the result side stalls; the
// rate is one beat per clock, set by a fully pipelined datapath of
// clip, multiply, sum, norm product and a 16-stage bit-by-bit ratio search
// (one quotient bit per stage, three lanes for shifts 0, +1 and -1).
// A stall on the result side holds the whole pipeline. Both results are
// Q1.15 in 0..32768; a zero norm gives 0.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_pair_similarity
    import wps_pkg::*;
#(
    parameter int SAMPLES = 6
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wren,
    input  wire logic [12:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // u_sample_0..5 then v_sample_0..5, 16 bits each
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cosine_similarity, best_shift_correlation
    output logic [31:0]       m_tdata
);

    localparam int LAST = STEPS;

    logic [CLIP_W-1:0] sample_clip_reg;
    logic              en;

    logic              v1_reg, v2_reg, v3_reg, vo_reg;
    logic [CLIP_W-1:0] u1_reg [SAMPLES];
    logic [CLIP_W-1:0] w1_reg [SAMPLES];
    logic [PROD_W-1:0] uu_reg [SAMPLES];
    logic [PROD_W-1:0] ww_reg [SAMPLES];
    logic [PROD_W-1:0] d0_reg [SAMPLES];
    logic [PROD_W-1:0] dp_reg [SAMPLES-1];
    logic [PROD_W-1:0] dm_reg [SAMPLES-1];
    sums_t             sum_reg [LANES];
    sums_t             sum_next [LANES];
    lane_t             it_reg [LAST+1][LANES];
    logic              iv_reg [LAST+1];
    logic [Q_W-1:0]    cos_reg, best_reg;

    assign en       = !vo_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = vo_reg;
    assign m_tdata  = {best_reg, cos_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_clip_reg <= 13'd5308;
        end else if (cfg_wren) begin
            sample_clip_reg <= cfg_wdata;
        end
    end

    function automatic logic [CLIP_W-1:0] clip_code(logic [RAW_W-1:0] raw,
                                                    logic [CLIP_W-1:0] lim);
        logic [CLIP_W-1:0] res;
        if (raw[RAW_W-1]) begin
            res = '0;
        end else if (raw[RAW_W-2:0] > {2'b00, lim}) begin
            res = lim;
        end else begin
            res = raw[CLIP_W-1:0];
        end
        return res;
    endfunction

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int i = 0; i <= LAST; i++) iv_reg[i] <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            iv_reg[0] <= v3_reg;
            for (int i = 1; i <= LAST; i++) iv_reg[i] <= iv_reg[i-1];
            vo_reg    <= iv_reg[LAST];
        end
    end

    // clip and products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int t = 0; t < SAMPLES; t++) begin
                u1_reg[t] <= clip_code(s_tdata[t*RAW_W +: RAW_W], sample_clip_reg);
                w1_reg[t] <= clip_code(s_tdata[(FIELDS+t)*RAW_W +: RAW_W],
                                       sample_clip_reg);
                uu_reg[t] <= u1_reg[t] * u1_reg[t];
                ww_reg[t] <= w1_reg[t] * w1_reg[t];
                d0_reg[t] <= u1_reg[t] * w1_reg[t];
            end
            for (int t = 0; t < SAMPLES - 1; t++) begin
                dp_reg[t] <= u1_reg[t] * w1_reg[t+1];
                dm_reg[t] <= u1_reg[t+1] * w1_reg[t];
            end
            for (int l = 0; l < LANES; l++) sum_reg[l] <= sum_next[l];
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) sum_next[l] = '0;
        for (int t = 0; t < SAMPLES; t++) begin
            sum_next[0].dot = sum_next[0].dot + SUM_W'(d0_reg[t]);
            sum_next[0].nu  = sum_next[0].nu + SUM_W'(uu_reg[t]);
            sum_next[0].nv  = sum_next[0].nv + SUM_W'(ww_reg[t]);
        end
        for (int t = 0; t < SAMPLES - 1; t++) begin
            sum_next[1].dot = sum_next[1].dot + SUM_W'(dp_reg[t]);
            sum_next[1].nu  = sum_next[1].nu + SUM_W'(uu_reg[t]);
            sum_next[1].nv  = sum_next[1].nv + SUM_W'(ww_reg[t+1]);
            sum_next[2].dot = sum_next[2].dot + SUM_W'(dm_reg[t]);
            sum_next[2].nu  = sum_next[2].nu + SUM_W'(uu_reg[t+1]);
            sum_next[2].nv  = sum_next[2].nv + SUM_W'(ww_reg[t]);
        end
    end

    // norm product and squared dot
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                it_reg[0][l].nz <= (sum_reg[l].nu != '0) && (sum_reg[l].nv != '0);
                it_reg[0][l].p  <= sum_reg[l].nu * sum_reg[l].nv;
                it_reg[0][l].d  <= {NORM_W'(sum_reg[l].dot) * NORM_W'(sum_reg[l].dot),
                                    30'd0};
                it_reg[0][l].s  <= '0;
                it_reg[0][l].a  <= '0;
                it_reg[0][l].r  <= '0;
            end
        end
    end

    // one quotient bit per stage: test (r+b)^2 * p <= d incrementally
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam int K = STEPS - 1 - g;
        lane_t nxt [LANES];
        always_comb begin
            logic [ACC_W-1:0] cand;
            for (int l = 0; l < LANES; l++) begin
                nxt[l] = it_reg[g][l];
                cand   = it_reg[g][l].s + (it_reg[g][l].a << (K + 1))
                       + (ACC_W'(it_reg[g][l].p) << (2 * K));
                if (!it_reg[g][l].r[Q_W-1] && cand <= ACC_W'(it_reg[g][l].d)) begin
                    nxt[l].s    = cand;
                    nxt[l].a    = it_reg[g][l].a + (ACC_W'(it_reg[g][l].p) << K);
                    nxt[l].r[K] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) it_reg[g+1][l] <= nxt[l];
            end
        end
    end

    // best of the three lanes
    always_ff @(posedge aclk) begin
        logic [Q_W-1:0] q0, q1, q2, m;
        if (en) begin
            q0 = it_reg[LAST][0].nz ? it_reg[LAST][0].r : '0;
            q1 = it_reg[LAST][1].nz ? it_reg[LAST][1].r : '0;
            q2 = it_reg[LAST][2].nz ? it_reg[LAST][2].r : '0;
            m  = q0;
            if (q1 > m) m = q1;
            if (q2 > m) m = q2;
            cos_reg  <= q0;
            best_reg <= m;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_waveform_pair_similarity.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_waveform_pair_similarity
// self-checking bench for the waveform pair similarity scorer
// ----------------------------------------------------------------------------
// A directed table of waveform pairs covers clip extremes, negative codes,
// zero norms, identical and shifted waveforms; random pairs follow under
// several clip settings. Each result beat is compared with an exact integer
// score prediction, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_waveform_pair_similarity;

    localparam int N_RANDOM = 1440;

    typedef struct packed {
        logic [15:0] cos_q;
        logic [15:0] best_q;
    } score_t;

    typedef struct {
        logic [191:0] data;
        logic         chk;
        score_t       want;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wren = 1'b0;
    logic [12:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;

    logic [12:0]  clip_level = 13'd5308;
    score_t       pending_scores[$];
    int           errors = 0;
    bit           hold_output = 1'b0;
    bit           sink_on = 1'b0;
    row_t         rows[$];

    waveform_pair_similarity #(.SAMPLES(6)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wren(cfg_wren), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint unsigned clip_sample(logic [15:0] raw);
        if (raw[15]) return 0;
        return (raw > {3'b0, clip_level}) ? clip_level : raw;
    endfunction

    // exact floor(32768 * dot / sqrt(nu * nv)) by bitwise search
    function automatic logic [15:0] q15_score(longint unsigned dot, longint unsigned nu,
                                              longint unsigned nv);
        logic [127:0] lhs, rhs;
        logic [16:0] r, cand;
        r = 0;
        if (nu == 0 || nv == 0) return 0;
        rhs = (128'(dot) * 128'(dot)) << 30;
        for (int b = 15; b >= 0; b--) begin
            cand = r | (17'd1 << b);
            lhs = 128'(cand) * 128'(cand) * 128'(nu) * 128'(nv);
            if (lhs <= rhs) r = cand;
        end
        cand = 17'd32768;
        lhs = 128'(cand) * 128'(cand) * 128'(nu) * 128'(nv);
        if (lhs <= rhs) r = cand;
        return r[15:0];
    endfunction

    function automatic logic [15:0] window_score(longint unsigned u[6], longint unsigned v[6],
                                                 int ou, int ov, int cnt);
        longint unsigned dot, nu, nv;
        dot = 0; nu = 0; nv = 0;
        for (int t = 0; t < cnt; t++) begin
            dot += u[t+ou] * v[t+ov];
            nu += u[t+ou] * u[t+ou];
            nv += v[t+ov] * v[t+ov];
        end
        return q15_score(dot, nu, nv);
    endfunction

    function automatic score_t predict_scores(logic [191:0] d);
        longint unsigned u[6], v[6];
        logic [15:0] s;
        score_t res;
        for (int i = 0; i < 6; i++) begin
            u[i] = clip_sample(d[16*i +: 16]);
            v[i] = clip_sample(d[16*(6+i) +: 16]);
        end
        res.cos_q = window_score(u, v, 0, 0, 6);
        res.best_q = res.cos_q;
        s = window_score(u, v, 0, 1, 5);
        if (s > res.best_q) res.best_q = s;
        s = window_score(u, v, 1, 0, 5);
        if (s > res.best_q) res.best_q = s;
        return res;
    endfunction

    function automatic logic [191:0] pack_pair(logic [15:0] u[6], logic [15:0] v[6]);
        logic [191:0] d;
        for (int i = 0; i < 6; i++) begin
            d[16*i +: 16] = u[i];
            d[16*(6+i) +: 16] = v[i];
        end
        return d;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random sample, weighted toward interesting codes
    function automatic logic [15:0] rand_code();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 16'($urandom);
            1: return 16'(clip_level);
            2: return 16'h0000;
            3: return 16'($urandom_range(16'h8000, 16'hFFFF));
            4: return 16'h7FFF;
            default: return 16'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic add_row(logic [191:0] d, logic chk, logic [15:0] c, logic [15:0] b);
        row_t r;
        r.data = d; r.chk = chk; r.want.cos_q = c; r.want.best_q = b;
        rows = {rows, r};
    endtask

    task automatic send_pair(logic [191:0] d, logic chk, score_t want);
        score_t p;
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= d;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = predict_scores(d);
        if (chk && p !== want) begin
            $error("table row disagrees with predictor: %h vs %h", want, p);
            errors++;
        end
        pending_scores = {pending_scores, p};
        @(negedge aclk);
    endtask

    task automatic write_clip(logic [12:0] val);
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        cfg_wdata <= val;
        cfg_wren <= 1'b1;
        @(negedge aclk);
        cfg_wren <= 1'b0;
        clip_level = val;
    endtask

    task automatic build_table();
        logic [15:0] u[6], v[6];
        for (int i = 0; i < 6; i++) begin u[i] = 16'd0; v[i] = 16'd0; end
        add_row(pack_pair(u, v), 1, 0, 0);
        for (int i = 0; i < 6; i++) begin u[i] = 16'h7FFF; v[i] = 16'h7FFF; end
        add_row(pack_pair(u, v), 1, 16'h8000, 16'h8000);
        for (int i = 0; i < 6; i++) begin u[i] = 16'hFFFF; v[i] = 16'h8000; end
        add_row(pack_pair(u, v), 1, 0, 0);
        for (int i = 0; i < 6; i++) begin u[i] = 16'd100; v[i] = 16'h8000; end
        add_row(pack_pair(u, v), 1, 0, 0);
        for (int i = 0; i < 6; i++) begin u[i] = 16'd0; v[i] = 16'd0; end
        u[0] = 16'd1000; v[5] = 16'd1000;
        add_row(pack_pair(u, v), 1, 0, 0);
        u[0] = 16'd0; u[1] = 16'd500; v[5] = 16'd0; v[2] = 16'd700;
        add_row(pack_pair(u, v), 1, 0, 16'h8000);
        u[1] = 16'd0; u[3] = 16'd900; v[2] = 16'd0; v[2] = 16'd300;
        add_row(pack_pair(u, v), 1, 0, 16'h8000);
        for (int i = 0; i < 6; i++) begin
            u[i] = 16'(i * 1000 + 7); v[i] = 16'(i * 1000 + 7);
        end
        add_row(pack_pair(u, v), 1, 16'h8000, 16'h8000);
        for (int i = 0; i < 6; i++) begin u[i] = 16'h5555; v[i] = 16'hAAAA; end
        add_row(pack_pair(u, v), 1, 0, 0);
        for (int i = 0; i < 6; i++) begin u[i] = 16'd0; v[i] = 16'd0; end
        u[2] = 16'd4000; v[3] = 16'd4000; v[0] = 16'd1;
        add_row(pack_pair(u, v), 0, 0, 0);
        for (int i = 0; i < 6; i++) begin u[i] = 16'(5309 + i); v[i] = 16'd5308; end
        add_row(pack_pair(u, v), 1, 16'h8000, 16'h8000);
        for (int i = 0; i < 6; i++) begin
            u[i] = (i % 2) ? 16'd8191 : 16'd1; v[i] = (i % 2) ? 16'd1 : 16'd8191;
        end
        add_row(pack_pair(u, v), 0, 0, 0);
    endtask

    initial begin
        logic [15:0] u[6], v[6];
        score_t none;
        none = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        sink_on = 1'b1;
        build_table();
        foreach (rows[i]) send_pair(rows[i].data, rows[i].chk, rows[i].want);

        hold_output = 1'b1;
        for (int n = 0; n < 60; n++) begin
            for (int i = 0; i < 12; i++) u[i % 6] = rand_code();
            for (int i = 0; i < 6; i++) v[i] = rand_code();
            send_pair(pack_pair(u, v), 0, none);
        end
        hold_output = 1'b0;

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_clip(13'd8191);
                1: write_clip(13'd0);
                2: write_clip(13'd1);
                3: write_clip(13'($urandom_range(2, 8190)));
                default: write_clip(13'd5308);
            endcase
            for (int n = 0; n < (ph == 1 ? 40 : N_RANDOM / 4); n++) begin
                for (int i = 0; i < 6; i++) begin
                    u[i] = rand_code(); v[i] = rand_code();
                end
                if ($urandom_range(0, 3) == 0) begin
                    // time-shifted copy of u with a random first sample
                    for (int i = 0; i < 6; i++) v[i] = (i == 0) ? rand_code() : u[i-1];
                end
                send_pair(pack_pair(u, v), 0, none);
            end
        end

        s_tvalid <= 1'b0;
        for (int c = 0; c < 100000 && pending_scores.size() != 0; c++) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (pending_scores.size() == 0 && errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // result side: random readiness plus one long hold-off
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (sink_on);
        forever begin
            @(negedge aclk);
            if (hold_output && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int c = 0; c < 200; c++) @(negedge aclk);
            end
            stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        score_t exp_s;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                $error("result beat with no pair outstanding: %h", m_tdata);
                errors++;
            end else begin
                exp_s = pending_scores.pop_front();
                if (m_tdata[15:0] !== exp_s.cos_q) begin
                    $error("cosine_similarity: expected %0d, got %0d",
                           exp_s.cos_q, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== exp_s.best_q) begin
                    $error("best_shift_correlation: expected %0d, got %0d",
                           exp_s.best_q, m_tdata[31:16]);
                    errors++;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/wps_pkg.sv
sv/waveform_pair_similarity.sv
tb/sv/tb_waveform_pair_similarity.sv
